// File: rtl/core/hfe_pkg.sv
// shared constants and types of the helical field evaluator
`default_nettype none

package hfe_pkg;

  localparam int POS_W    = 32;
  localparam int RAD_W    = 31;
  localparam int SQ_W     = 64;
  localparam int RSQ_W    = 62;
  localparam int MAX_FRAC = 30;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [2:0] REG_INNER = 3'd0;
  localparam logic [2:0] REG_OUTER = 3'd1;
  localparam logic [2:0] REG_AMP_X = 3'd2;
  localparam logic [2:0] REG_AMP_Y = 3'd3;
  localparam logic [2:0] REG_AMP_Z = 3'd4;

  typedef struct packed {
    logic in_shell;
    logic neg_x;
    logic neg_y;
    logic cap_x;
    logic cap_y;
  } hfe_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/hfe_front.sv
// front stages: magnitudes, squares, shell test and residual seeds
`default_nettype none

module hfe_front #(
  parameter int F  = 24,
  parameter int RW = 2 * F + 68,
  parameter int QW = F + 67
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic [61:0]              inner_sq_i,
  input  logic [61:0]              outer_sq_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output hfe_pkg::hfe_flags_t      flags_o,
  output logic [63:0]              s_o,
  output logic signed [RW-1:0]     rx_o,
  output logic signed [RW-1:0]     ry_o,
  output logic signed [QW-1:0]     qx_o,
  output logic signed [QW-1:0]     qy_o
);
  import hfe_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic              rdy1, rdy2, rdy3;
  logic [POS_W-1:0]  ax1_r, ay1_r, ax_nxt, ay_nxt;
  logic              nx1_r, ny1_r, nx2_r, ny2_r;
  logic [SQ_W-1:0]   sqx2_r, sqy2_r, sqx_nxt, sqy_nxt;
  logic [SQ_W-1:0]   s3_r, s_nxt;
  logic signed [RW-1:0] rx3_r, ry3_r, rx_nxt, ry_nxt;
  logic signed [QW-1:0] q3_r, q_nxt;
  hfe_flags_t        fl3_r, fl_nxt;

  assign rdy3    = !v3_r || ready_i;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign ready_o = rdy1;

  assign ax_nxt = pos_x_i[31] ? (~$unsigned(pos_x_i) + 32'd1) : $unsigned(pos_x_i);
  assign ay_nxt = pos_y_i[31] ? (~$unsigned(pos_y_i) + 32'd1) : $unsigned(pos_y_i);

  assign sqx_nxt = {32'd0, ax1_r} * {32'd0, ax1_r};
  assign sqy_nxt = {32'd0, ay1_r} * {32'd0, ay1_r};

  always_comb begin
    s_nxt           = sqx2_r + sqy2_r;
    fl_nxt.in_shell = (s_nxt > {2'b00, inner_sq_i}) && (s_nxt < {2'b00, outer_sq_i});
    fl_nxt.neg_x    = nx2_r;
    fl_nxt.neg_y    = ny2_r;
    fl_nxt.cap_x    = 1'b0;
    fl_nxt.cap_y    = 1'b0;
    rx_nxt          = $signed((RW'(sqx2_r) << (2 * F + 2)) - RW'(s_nxt));
    ry_nxt          = $signed((RW'(sqy2_r) << (2 * F + 2)) - RW'(s_nxt));
    q_nxt           = $signed({QW{1'b0}} - QW'(s_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= valid_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && valid_i) begin
      ax1_r <= ax_nxt;
      ay1_r <= ay_nxt;
      nx1_r <= pos_x_i[31];
      ny1_r <= pos_y_i[31];
    end
    if (rdy2 && v1_r) begin
      sqx2_r <= sqx_nxt;
      sqy2_r <= sqy_nxt;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
    end
    if (rdy3 && v2_r) begin
      s3_r  <= s_nxt;
      rx3_r <= rx_nxt;
      ry3_r <= ry_nxt;
      q3_r  <= q_nxt;
      fl3_r <= fl_nxt;
    end
  end

  assign valid_o = v3_r;
  assign flags_o = fl3_r;
  assign s_o     = s3_r;
  assign rx_o    = rx3_r;
  assign ry_o    = ry3_r;
  assign qx_o    = q3_r;
  assign qy_o    = q3_r;

endmodule

`default_nettype wire

// File: rtl/core/hfe_cell.sv
// one cell of the direction chain: settles one bit of both unit components
`default_nettype none

module hfe_cell #(
  parameter int F   = 24,
  parameter int RW  = 2 * F + 68,
  parameter int QW  = F + 67,
  parameter int BIT = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  hfe_pkg::hfe_flags_t      flags_i,
  input  logic [63:0]              s_i,
  input  logic signed [RW-1:0]     rx_i,
  input  logic signed [RW-1:0]     ry_i,
  input  logic signed [QW-1:0]     qx_i,
  input  logic signed [QW-1:0]     qy_i,
  input  logic [F:0]               mx_i,
  input  logic [F:0]               my_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output hfe_pkg::hfe_flags_t      flags_o,
  output logic [63:0]              s_o,
  output logic signed [RW-1:0]     rx_o,
  output logic signed [RW-1:0]     ry_o,
  output logic signed [QW-1:0]     qx_o,
  output logic signed [QW-1:0]     qy_o,
  output logic [F:0]               mx_o,
  output logic [F:0]               my_o
);
  import hfe_pkg::*;

  localparam int         SH_Q     = BIT + 2;
  localparam int         SH_S     = 2 * BIT + 2;
  localparam int         SH_A     = BIT + 1;
  localparam logic       IS_TOP   = (BIT == F);
  localparam logic [F:0] ONE      = (F + 1)'(1);
  localparam logic [F:0] BIT_ONE  = ONE << BIT;
  localparam logic [F:0] TOP_ONE  = ONE << F;
  localparam logic [F:0] LOW_MASK = BIT_ONE - ONE;

  logic                 valid_r;
  hfe_flags_t           flags_r, flags_nxt;
  logic [SQ_W-1:0]      s_r;
  logic signed [RW-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [QW-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic [F:0]           mx_r, my_r, mx_nxt, my_nxt;
  logic signed [RW-1:0] dx, dy, rdx, rdy;
  logic signed [QW-1:0] q_step;
  logic                 acc_x, acc_y;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    // candidate cost: 2^(b+2)*t*s + 4^(b+1)*s
    dx     = $signed(($signed(RW'(qx_i)) <<< SH_Q) + (RW'(s_i) << SH_S));
    dy     = $signed(($signed(RW'(qy_i)) <<< SH_Q) + (RW'(s_i) << SH_S));
    rdx    = rx_i - dx;
    rdy    = ry_i - dy;
    acc_x  = !flags_i.cap_x && !rdx[RW-1];
    acc_y  = !flags_i.cap_y && !rdy[RW-1];
    q_step = $signed(QW'(s_i) << SH_A);
    rx_nxt = acc_x ? rdx : rx_i;
    ry_nxt = acc_y ? rdy : ry_i;
    qx_nxt = acc_x ? (qx_i + q_step) : qx_i;
    qy_nxt = acc_y ? (qy_i + q_step) : qy_i;
    mx_nxt = acc_x ? (mx_i | BIT_ONE) : mx_i;
    my_nxt = acc_y ? (my_i | BIT_ONE) : my_i;
    flags_nxt       = flags_i;
    flags_nxt.cap_x = flags_i.cap_x || (acc_x && IS_TOP);
    flags_nxt.cap_y = flags_i.cap_y || (acc_y && IS_TOP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      flags_r <= flags_nxt;
      s_r     <= s_i;
      rx_r    <= rx_nxt;
      ry_r    <= ry_nxt;
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
    end
  end

  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign s_o     = s_r;
  assign rx_o    = rx_r;
  assign ry_o    = ry_r;
  assign qx_o    = qx_r;
  assign qy_o    = qy_r;
  assign mx_o    = mx_r;
  assign my_o    = my_r;

`ifndef NO_ASSERTIONS
  a_cap_full: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && flags_r.cap_x |-> mx_r == TOP_ONE)
    else $error("capped x component is not the full unit");

  a_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((mx_r & LOW_MASK) == '0) && ((my_r & LOW_MASK) == '0))
    else $error("bits below this cell already set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !ready_i |=> valid_r && $stable(rx_r) && $stable(my_r))
    else $error("stalled cell lost its word");
`endif

endmodule

`default_nettype wire

// File: rtl/core/hfe_back.sv
// back stages: amplitude products, rounding, saturation and output register
`default_nettype none

module hfe_back #(
  parameter int F = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  hfe_pkg::hfe_flags_t      flags_i,
  input  logic [F:0]               mx_i,
  input  logic [F:0]               my_i,
  input  logic signed [31:0]       amp_x_i,
  input  logic signed [31:0]       amp_y_i,
  input  logic signed [31:0]       amp_z_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [31:0]       field_x_o,
  output logic signed [31:0]       field_y_o,
  output logic signed [31:0]       field_z_o,
  output logic                     inside_o
);
  import hfe_pkg::*;

  localparam logic [SQ_W-1:0] HALF    = SQ_W'(1) << (F - 1);
  localparam logic [SQ_W-1:0] NEG_LIM = SQ_W'(64'h0000_0000_8000_0000);
  localparam logic [SQ_W-1:0] POS_LIM = SQ_W'(64'h0000_0000_7FFF_FFFF);

  logic              v1_r, v2_r, rdy1, rdy2;
  logic [POS_W-1:0]  amx, amy;
  logic [SQ_W-1:0]   magx1_r, magy1_r, magx_nxt, magy_nxt;
  logic              negx1_r, negy1_r, in1_r;
  logic [POS_W-1:0]  fx2_r, fy2_r, fz2_r, fx_nxt, fy_nxt, fz_nxt;
  logic              in2_r;

  function automatic logic [31:0] round_sat(input logic [63:0] mag, input logic neg);
    logic [63:0] q;
    begin
      q = (mag + HALF) >> F;
      if (mag == '0) begin
        round_sat = '0;
      end else if (neg) begin
        if (q > NEG_LIM) q = NEG_LIM;
        round_sat = 32'(~q + 64'd1);
      end else begin
        if (q > POS_LIM) q = POS_LIM;
        round_sat = q[31:0];
      end
    end
  endfunction

  assign rdy2    = !v2_r || ready_i;
  assign rdy1    = !v1_r || rdy2;
  assign ready_o = rdy1;

  assign amx      = amp_x_i[31] ? (~$unsigned(amp_x_i) + 32'd1) : $unsigned(amp_x_i);
  assign amy      = amp_y_i[31] ? (~$unsigned(amp_y_i) + 32'd1) : $unsigned(amp_y_i);
  assign magx_nxt = {32'd0, amx} * SQ_W'(my_i);
  assign magy_nxt = {32'd0, amy} * SQ_W'(mx_i);

  // field_x carries the extra negation of -ampx*y/r
  always_comb begin
    fx_nxt = in1_r ? round_sat(magx1_r, negx1_r) : '0;
    fy_nxt = in1_r ? round_sat(magy1_r, negy1_r) : '0;
    fz_nxt = in1_r ? $unsigned(amp_z_i) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= valid_i;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && valid_i) begin
      magx1_r <= magx_nxt;
      magy1_r <= magy_nxt;
      negx1_r <= ~(amp_x_i[31] ^ flags_i.neg_y);
      negy1_r <= amp_y_i[31] ^ flags_i.neg_x;
      in1_r   <= flags_i.in_shell;
    end
    if (rdy2 && v1_r) begin
      fx2_r <= fx_nxt;
      fy2_r <= fy_nxt;
      fz2_r <= fz_nxt;
      in2_r <= in1_r;
    end
  end

  assign valid_o   = v2_r;
  assign field_x_o = $signed(fx2_r);
  assign field_y_o = $signed(fy2_r);
  assign field_z_o = $signed(fz2_r);
  assign inside_o  = in2_r;

endmodule

`default_nettype wire

// File: rtl/core/helical_field_evaluator_core.sv
// top level of the helical field evaluator: registers, front, cell chain, back
//
// channel   dir   handshake                     payload
// in_       in    in_tvalid / in_tready         tdata: pos_x, pos_y, pos_z
// out_      out   out_tvalid / out_tready       tdata: field_x, field_y, field_z; tuser: inside
// cfg_      in    psel, penable, pwrite, pready 32-bit registers at byte address 4*index
//
// one word per cycle sustained while out_tready is high; F = min(CORDIC_STAGES, 30)
// the chain of F + 1 cells settles one unit-vector bit per cell
// reset clears stage valid bits and the config registers; no clearing pass
// every stage holds its word under backpressure and fills any bubble ahead of it
`default_nettype none

module helical_field_evaluator_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,     // pos_x, pos_y, pos_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,    // field_x, field_y, field_z
  output logic        out_tuser,    // inside_shell
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hfe_pkg::*;

  localparam int F  = (CORDIC_STAGES > MAX_FRAC) ? MAX_FRAC : CORDIC_STAGES;
  localparam int RW = 2 * F + 68;
  localparam int QW = F + 67;

  logic [RAD_W-1:0]  inner_r, outer_r;
  logic [POS_W-1:0]  amp_x_r, amp_y_r, amp_z_r;
  logic [RSQ_W-1:0]  inner_sq_r, outer_sq_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic                 v_c   [0:F+1];
  logic                 rdy_c [0:F+1];
  hfe_flags_t           fl_c  [0:F+1];
  logic [SQ_W-1:0]      s_c   [0:F+1];
  logic signed [RW-1:0] rx_c  [0:F+1];
  logic signed [RW-1:0] ry_c  [0:F+1];
  logic signed [QW-1:0] qx_c  [0:F+1];
  logic signed [QW-1:0] qy_c  [0:F+1];
  logic [F:0]           mx_c  [0:F+1];
  logic [F:0]           my_c  [0:F+1];

  logic signed [31:0] fx, fy, fz;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= '0;
      amp_x_r <= '0;
      amp_y_r <= '0;
      amp_z_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INNER: inner_r <= cfg_pwdata[RAD_W-1:0];
        REG_OUTER: outer_r <= cfg_pwdata[RAD_W-1:0];
        REG_AMP_X: amp_x_r <= cfg_pwdata;
        REG_AMP_Y: amp_y_r <= cfg_pwdata;
        REG_AMP_Z: amp_z_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INNER: cfg_prdata = {1'b0, inner_r};
      REG_OUTER: cfg_prdata = {1'b0, outer_r};
      REG_AMP_X: cfg_prdata = amp_x_r;
      REG_AMP_Y: cfg_prdata = amp_y_r;
      REG_AMP_Z: cfg_prdata = amp_z_r;
      default:   cfg_prdata = '0;
    endcase
  end

  // bound squares follow the registers in the next cycle
  always_ff @(posedge clk) begin
    inner_sq_r <= {31'd0, inner_r} * {31'd0, inner_r};
    outer_sq_r <= {31'd0, outer_r} * {31'd0, outer_r};
  end

  hfe_front #(.F(F), .RW(RW), .QW(QW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (in_tvalid),
    .ready_o    (in_tready),
    .pos_x_i    ($signed(in_tdata[31:0])),
    .pos_y_i    ($signed(in_tdata[63:32])),
    .inner_sq_i (inner_sq_r),
    .outer_sq_i (outer_sq_r),
    .valid_o    (v_c[0]),
    .ready_i    (rdy_c[0]),
    .flags_o    (fl_c[0]),
    .s_o        (s_c[0]),
    .rx_o       (rx_c[0]),
    .ry_o       (ry_c[0]),
    .qx_o       (qx_c[0]),
    .qy_o       (qy_c[0])
  );

  assign mx_c[0] = '0;
  assign my_c[0] = '0;

  for (genvar k = 0; k <= F; k++) begin : g_cell
    hfe_cell #(.F(F), .RW(RW), .QW(QW), .BIT(F - k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (v_c[k]),
      .ready_o (rdy_c[k]),
      .flags_i (fl_c[k]),
      .s_i     (s_c[k]),
      .rx_i    (rx_c[k]),
      .ry_i    (ry_c[k]),
      .qx_i    (qx_c[k]),
      .qy_i    (qy_c[k]),
      .mx_i    (mx_c[k]),
      .my_i    (my_c[k]),
      .valid_o (v_c[k+1]),
      .ready_i (rdy_c[k+1]),
      .flags_o (fl_c[k+1]),
      .s_o     (s_c[k+1]),
      .rx_o    (rx_c[k+1]),
      .ry_o    (ry_c[k+1]),
      .qx_o    (qx_c[k+1]),
      .qy_o    (qy_c[k+1]),
      .mx_o    (mx_c[k+1]),
      .my_o    (my_c[k+1])
    );
  end

  hfe_back #(.F(F)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (v_c[F+1]),
    .ready_o   (rdy_c[F+1]),
    .flags_i   (fl_c[F+1]),
    .mx_i      (mx_c[F+1]),
    .my_i      (my_c[F+1]),
    .amp_x_i   ($signed(amp_x_r)),
    .amp_y_i   ($signed(amp_y_r)),
    .amp_z_i   ($signed(amp_z_r)),
    .valid_o   (out_tvalid),
    .ready_i   (out_tready),
    .field_x_o (fx),
    .field_y_o (fy),
    .field_z_o (fz),
    .inside_o  (out_tuser)
  );

  assign out_tdata = {$unsigned(fz), $unsigned(fy), $unsigned(fx)};

endmodule

`default_nettype wire
